/* sv/sm4_block_encrypt_assert.svh */
// Assertion macros shared by the SM4 checker.
// Each macro is clocked on clk_i and disabled while rst_ni is low.
`ifndef SM4_BLOCK_ENCRYPT_ASSERT_SVH
`define SM4_BLOCK_ENCRYPT_ASSERT_SVH

// Same-cycle implication.
`define SM4_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication.
`define SM4_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sm4_pkg.sv */
package sm4_pkg;

  typedef logic [31:0] word_t;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 2'd1;

  localparam int unsigned Rounds  = 32;
  localparam int unsigned RoundW  = $clog2(Rounds);

  // System parameter FK, XORed onto the key words.
  localparam word_t FK0 = 32'ha3b1bac6;
  localparam word_t FK1 = 32'h56aa3350;
  localparam word_t FK2 = 32'h677d9197;
  localparam word_t FK3 = 32'hb27022dc;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,
    8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
    8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,
    8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,
    8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
    8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,
    8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,
    8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
    8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,
    8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,
    8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
    8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,
    8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,
    8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
    8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,
    8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,
    8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // Byte-wise S-box substitution of one word.
  function automatic word_t tau(word_t v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // Data round transform: S-box, then L.
  function automatic word_t t_data(word_t v);
    word_t b;
    b = tau(v);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
             ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

  // Key schedule transform: S-box, then L'.
  function automatic word_t t_key(word_t v);
    word_t b;
    b = tau(v);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  // CK constant of a round: byte j is (4i + j) * 7 mod 256, MSB first.
  function automatic word_t ck_word(logic [RoundW-1:0] i);
    word_t w;
    logic [7:0] base;
    base = {1'b0, i, 2'b00};
    for (int j = 0; j < 4; j++) begin
      w[31-8*j -: 8] = 8'((base + 8'(j)) * 8'd7);
    end
    return w;
  endfunction

endpackage

/* sv/sm4_intf.sv */
// Plaintext channel.
interface sm4_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, output block_high, output block_low, input ready);
  modport sink (input valid, input block_high, input block_low, output ready);
endinterface

// Ciphertext channel.
interface sm4_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  modport source (output valid, output cipher_high, output cipher_low, input ready);
  modport sink (input valid, input cipher_high, input cipher_low, output ready);
endinterface

// Configuration write channel.
interface sm4_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sm4_pkg::CfgIdxW-1:0]  index;
  logic [63:0]                  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/sm4_round.sv */
// One SM4 round: key expansion step and data round, shared by all 32 rounds.
module sm4_round (
  input  sm4_pkg::word_t                    data_i [4],
  input  sm4_pkg::word_t                    key_i [4],
  input  logic [sm4_pkg::RoundW-1:0]        round_i,
  output sm4_pkg::word_t                    rk_o,
  output sm4_pkg::word_t                    x_o
);
  import sm4_pkg::*;

  // Round key from the sliding key window.
  assign rk_o = key_i[0] ^ t_key(key_i[1] ^ key_i[2] ^ key_i[3] ^ ck_word(round_i));

  // New data word from the sliding data window.
  assign x_o = data_i[0] ^ t_data(data_i[1] ^ data_i[2] ^ data_i[3] ^ rk_o);

endmodule

/* sv/sm4_block_encrypt.sv */
// Channel  Port   Dir  Payload
// blk      blk_i  in   block_high, block_low (plaintext, 64 + 64 bits)
// res      res_o  out  cipher_high, cipher_low (ciphertext, 64 + 64 bits)
// cfg      cfg_i  in   index, data (key_high = 0, key_low = 1)
//
// The accepting edge loads the windows, then the shared round unit runs one round per
// cycle through all rounds and the last round loads the result register. The input is
// not ready while rounds run; the next item is taken while a result still waits. If
// the result register is still full after the last round, the block holds until it
// drains. Reset clears the keys to zero and all control state; the config port is
// always ready.
module sm4_block_encrypt (
  input  logic      clk_i,
  input  logic      rst_ni,
  sm4_blk_if.sink   blk_i,
  sm4_res_if.source res_o,
  sm4_cfg_if.sink   cfg_i
);
  import sm4_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StHold
  } state_e;

  state_e              state_q, state_d;
  logic [RoundW-1:0]   round_q, round_d;
  logic                res_valid_q, res_valid_d;
  logic [63:0]         res_hi_q, res_hi_d;
  logic [63:0]         res_lo_q, res_lo_d;
  logic [63:0]         key_high_q, key_low_q;
  word_t               data_q [4];
  word_t               key_q [4];
  word_t               rk;
  word_t               x;
  logic                in_acc;
  logic                slot_free;
  logic                load_res;
  logic                last_round;

  assign cfg_i.ready = 1'b1;
  assign blk_i.ready = (state_q == StIdle);
  assign in_acc      = blk_i.valid && blk_i.ready;
  assign slot_free   = !res_valid_q || res_o.ready;
  assign last_round  = &round_q;

  assign res_o.valid       = res_valid_q;
  assign res_o.cipher_high = res_hi_q;
  assign res_o.cipher_low  = res_lo_q;

  // Shared round unit.
  sm4_round u_round (
    .data_i  (data_q),
    .key_i   (key_q),
    .round_i (round_q),
    .rk_o    (rk),
    .x_o     (x)
  );

  // Sequencer next state and result loading.
  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    load_res    = 1'b0;
    res_hi_d    = {data_q[3], data_q[2]};
    res_lo_d    = {data_q[1], data_q[0]};
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StRun;
          round_d = '0;
        end
      end
      StRun: begin
        round_d  = round_q + RoundW'(1);
        res_hi_d = {x, data_q[3]};
        res_lo_d = {data_q[2], data_q[1]};
        if (last_round) begin
          if (slot_free) begin
            load_res = 1'b1;
            state_d  = StIdle;
          end else begin
            state_d  = StHold;
          end
        end
      end
      StHold: begin
        if (slot_free) begin
          load_res = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    res_valid_d = load_res || (res_valid_q && !res_o.ready);
  end

  // State, round counter and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      round_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Key registers, written through the config port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == RegKeyHigh) begin
        key_high_q <= cfg_i.data;
      end else if (cfg_i.index == RegKeyLow) begin
        key_low_q <= cfg_i.data;
      end
    end
  end

  // Sliding data and key windows; loaded per item, shifted per round.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      data_q[0] <= blk_i.block_high[63:32];
      data_q[1] <= blk_i.block_high[31:0];
      data_q[2] <= blk_i.block_low[63:32];
      data_q[3] <= blk_i.block_low[31:0];
      key_q[0]  <= key_high_q[63:32] ^ FK0;
      key_q[1]  <= key_high_q[31:0] ^ FK1;
      key_q[2]  <= key_low_q[63:32] ^ FK2;
      key_q[3]  <= key_low_q[31:0] ^ FK3;
    end else if (state_q == StRun) begin
      data_q[0] <= data_q[1];
      data_q[1] <= data_q[2];
      data_q[2] <= data_q[3];
      data_q[3] <= x;
      key_q[0]  <= key_q[1];
      key_q[1]  <= key_q[2];
      key_q[2]  <= key_q[3];
      key_q[3]  <= rk;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_hi_q <= res_hi_d;
      res_lo_q <= res_lo_d;
    end
  end

endmodule

/* sv/sm4_block_encrypt_checker.sv */
`include "sm4_block_encrypt_assert.svh"

// Port-level checks of the SM4 block.
module sm4_block_encrypt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] cipher_high_i,
  input logic [63:0] cipher_low_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // The block is busy right after taking an item.
  `SM4_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready_i, "ready after accept")

  // No result shows up in the cycle after an item starts on an empty output.
  `SM4_ASSERT_NXT(a_no_early_result, in_acc && !out_valid_i, !out_valid_i, "early result")

  // A result appears once the rounds of an item accepted on an empty output complete.
  `SM4_ASSERT_IMP(a_latency, in_acc && !out_valid_i, ##33 out_valid_i, "latency")

  // A stalled result holds.
  `SM4_ASSERT_NXT(a_res_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(cipher_high_i) && $stable(cipher_low_i), "result changed")

endmodule

bind sm4_block_encrypt sm4_block_encrypt_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (blk_i.valid),
  .in_ready_i    (blk_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .cipher_high_i (res_o.cipher_high),
  .cipher_low_i  (res_o.cipher_low)
);
